/* hdl/cvs_pkg.sv */
package cvs_pkg;

  localparam int KSIZE             = 4;
  localparam int TAPS              = KSIZE * KSIZE;
  localparam int PIXEL_W           = 8;
  localparam int PROD_W            = 2 * PIXEL_W;
  localparam int PSUM_W            = PROD_W + 2;
  localparam int SUM_W             = 20;
  localparam int ROW_W             = 12;
  localparam int COL_W             = 7;
  localparam int IMG_WIDTH_W       = 8;
  localparam int IMG_HEIGHT_W      = 13;
  localparam int CFG_W             = 64;
  localparam int CFG_INDEX_W       = 2;
  localparam int ODATA_W           = 40;
  localparam int QUEUE_DEPTH       = 4;
  localparam int MAX_WIDTH_DEFAULT = 128;
  localparam int MAX_HEIGHT        = 4096;

  localparam logic [CFG_W-1:0] KERNEL_LOW_RESET  = 64'h0001_0100_0100_0001;
  localparam logic [CFG_W-1:0] KERNEL_HIGH_RESET = 64'h0100_0001_0001_0100;
  localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 8'd100;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KERNEL_LOW   = 2'd0,
    REG_KERNEL_HIGH  = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_index_t;

  // window byte k sits at row k/4, column k%4; byte 0 is the oldest row, oldest column
  typedef logic [TAPS-1:0][PIXEL_W-1:0] window_t;

  typedef struct packed {
    logic             last;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
  } result_tag_t;

  typedef struct packed {
    window_t     win;
    result_tag_t tag;
  } entry_t;

endpackage

/* hdl/cvs_front.sv */
module cvs_front #(
  parameter int MAX_WIDTH = cvs_pkg::MAX_WIDTH_DEFAULT,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cvs_pkg::PIXEL_W-1:0]      s_tdata,
  input  logic                             restart,
  input  logic [CW-1:0]                    width_last,
  input  logic [cvs_pkg::ROW_W-1:0]        height_last,
  output logic                             push,
  output cvs_pkg::entry_t                  push_entry,
  input  logic                             push_ready
);

  localparam int CXW = (CW > cvs_pkg::COL_W) ? CW : cvs_pkg::COL_W;
  localparam int PW  = cvs_pkg::PIXEL_W;
  localparam int LW  = (cvs_pkg::KSIZE - 1) * PW;

  logic [CW-1:0]               col_cnt;
  logic [cvs_pkg::ROW_W-1:0]   row_cnt;

  // line buffer: one entry per column, the three previous rows packed oldest lowest
  logic [LW-1:0]               line_mem [MAX_WIDTH];
  logic [LW-1:0]               line_rd;

  logic                        s1_valid;
  logic [PW-1:0]               s1_px;
  logic [CW-1:0]               s1_col;
  logic                        s1_produce;
  cvs_pkg::result_tag_t        s1_tag;

  cvs_pkg::window_t            window;
  cvs_pkg::window_t            window_next;

  logic                        accept;
  logic                        s1_fire;
  logic                        produce;
  cvs_pkg::result_tag_t        tag;
  logic [CXW-1:0]              col_off;
  logic [cvs_pkg::KSIZE-1:0][PW-1:0] column;

  assign accept   = s_tvalid && s_tready;
  assign s1_fire  = s1_valid && (!s1_produce || push_ready);
  assign s_tready = !s1_valid || s1_fire;

  // classify at acceptance: does this pixel complete a window, and where
  always_comb begin
    col_off     = CXW'(col_cnt) - CXW'(cvs_pkg::KSIZE - 1);
    produce     = (row_cnt >= cvs_pkg::ROW_W'(cvs_pkg::KSIZE - 1)) &&
                  (col_cnt >= CW'(cvs_pkg::KSIZE - 1));
    tag.out_row = row_cnt - cvs_pkg::ROW_W'(cvs_pkg::KSIZE - 1);
    tag.out_col = col_off[cvs_pkg::COL_W-1:0];
    tag.last    = (row_cnt == height_last) && (col_cnt == width_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (restart) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_cnt == width_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == height_last) ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= s_tdata;
      s1_col     <= col_cnt;
      s1_produce <= produce;
      s1_tag     <= tag;
    end
  end

  // read the column at acceptance, write it back shifted up by one row when the item leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col_cnt];
    end
    if (s1_fire) begin
      line_mem[s1_col] <= {s1_px, line_rd[LW-1:PW]};
    end
  end

  always_comb begin
    column[0] = line_rd[PW-1:0];
    column[1] = line_rd[2*PW-1:PW];
    column[2] = line_rd[3*PW-1:2*PW];
    column[3] = s1_px;
    for (int i = 0; i < cvs_pkg::KSIZE; i++) begin
      for (int j = 0; j < cvs_pkg::KSIZE - 1; j++) begin
        window_next[i*cvs_pkg::KSIZE + j] = window[i*cvs_pkg::KSIZE + j + 1];
      end
      window_next[i*cvs_pkg::KSIZE + cvs_pkg::KSIZE - 1] = column[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_fire) begin
      window <= window_next;
    end
  end

  assign push           = s1_fire && s1_produce;
  assign push_entry.win = window_next;
  assign push_entry.tag = s1_tag;

endmodule

/* hdl/cvs_queue.sv */
module cvs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cvs_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output cvs_pkg::entry_t pop_entry
);

  localparam int PTR_W = $clog2(cvs_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cvs_pkg::entry_t  slots [cvs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(cvs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/cvs_back.sv */
module cvs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  cvs_pkg::window_t               taps,
  input  logic                           pop_valid,
  input  cvs_pkg::entry_t                pop_entry,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cvs_pkg::ODATA_W-1:0]    m_tdata,
  output logic                           m_tlast
);

  localparam int NGRP = cvs_pkg::TAPS / cvs_pkg::KSIZE;

  logic                                         a_valid;
  logic [cvs_pkg::TAPS-1:0][cvs_pkg::PROD_W-1:0] a_prod;
  cvs_pkg::result_tag_t                         a_tag;

  logic                                         b_valid;
  logic [NGRP-1:0][cvs_pkg::PSUM_W-1:0]         b_psum;
  cvs_pkg::result_tag_t                         b_tag;

  logic [cvs_pkg::SUM_W-1:0]                    o_sum;
  cvs_pkg::result_tag_t                         o_tag;

  logic                                         o_free;
  logic                                         b_free;
  logic                                         a_free;
  logic [NGRP-1:0][cvs_pkg::PSUM_W-1:0]         psum;
  logic [cvs_pkg::SUM_W-1:0]                    total;

  assign o_free = !m_tvalid || m_tready;
  assign b_free = !b_valid || o_free;
  assign a_free = !a_valid || b_free;
  assign pop    = pop_valid && a_free;

  // products, one small multiplier per tap
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < cvs_pkg::TAPS; k++) begin
        a_prod[k] <= taps[k] * pop_entry.win[k];
      end
      a_tag <= pop_entry.tag;
    end
  end

  // one partial sum per window row
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      psum[g] = '0;
      for (int j = 0; j < cvs_pkg::KSIZE; j++) begin
        psum[g] = psum[g] + cvs_pkg::PSUM_W'(a_prod[g*cvs_pkg::KSIZE + j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid) begin
      b_psum <= psum;
      b_tag  <= a_tag;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + cvs_pkg::SUM_W'(b_psum[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_free) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && b_valid) begin
      o_sum <= total;
      o_tag <= b_tag;
    end
  end

  assign m_tdata = {1'b0, o_tag.out_col, o_tag.out_row, o_sum};
  assign m_tlast = o_tag.last;

endmodule

/* hdl/conv4x4_valid_stream_unit.sv */
// Streaming 4x4 valid cross-correlation of an 8-bit image with an unsigned 8-bit kernel.
// Pixels enter in row-major order, one item per clock while the queue has room; the
// rate is set by the line buffer, a single memory of MAX_WIDTH entries read once and
// written once per pixel. A result is queued, then registered as products, row sums and
// total, carrying the window's top-left row and column; tlast marks the frame's final
// result. Writing image_width or image_height restarts the frame count; write registers
// only while no item is in flight. Line buffer contents are not cleared at reset.
module conv4x4_valid_stream_unit #(
  parameter int MAX_WIDTH = cvs_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cvs_pkg::PIXEL_W-1:0]        s_tdata,    // pixel[7:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cvs_pkg::ODATA_W-1:0]        m_tdata,    // sum[19:0], out_row[31:20],
                                                         // out_col[38:32], zero[39]
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [cvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cvs_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = cvs_pkg::IMG_HEIGHT_W;

  function automatic logic [CW-1:0] width_last_of(input logic [cvs_pkg::IMG_WIDTH_W-1:0] raw);
    logic [HW-1:0] w;
    w = HW'(raw);
    if (w < HW'(cvs_pkg::KSIZE)) begin
      w = HW'(cvs_pkg::KSIZE);
    end else if (w > HW'(MAX_WIDTH)) begin
      w = HW'(MAX_WIDTH);
    end
    return CW'(w - HW'(1));
  endfunction

  function automatic logic [cvs_pkg::ROW_W-1:0] height_last_of(input logic [HW-1:0] raw);
    logic [HW-1:0] h;
    h = raw;
    if (h < HW'(cvs_pkg::KSIZE)) begin
      h = HW'(cvs_pkg::KSIZE);
    end else if (h > HW'(cvs_pkg::MAX_HEIGHT)) begin
      h = HW'(cvs_pkg::MAX_HEIGHT);
    end
    return cvs_pkg::ROW_W'(h - HW'(1));
  endfunction

  logic [cvs_pkg::CFG_W-1:0]   kernel_low;
  logic [cvs_pkg::CFG_W-1:0]   kernel_high;
  logic [CW-1:0]               width_last;
  logic [cvs_pkg::ROW_W-1:0]   height_last;
  logic                        restart;
  cvs_pkg::window_t            taps;

  logic                        push;
  logic                        push_ready;
  cvs_pkg::entry_t             push_entry;
  logic                        pop;
  logic                        pop_valid;
  cvs_pkg::entry_t             pop_entry;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cvs_pkg::reg_index_t'(cfg_index))
        cvs_pkg::REG_IMAGE_WIDTH,
        cvs_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
        cvs_pkg::REG_KERNEL_LOW,
        cvs_pkg::REG_KERNEL_HIGH:  restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_low  <= cvs_pkg::KERNEL_LOW_RESET;
      kernel_high <= cvs_pkg::KERNEL_HIGH_RESET;
      width_last  <= width_last_of(cvs_pkg::IMAGE_WIDTH_RESET);
      height_last <= height_last_of(cvs_pkg::IMAGE_HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cvs_pkg::reg_index_t'(cfg_index))
        cvs_pkg::REG_KERNEL_LOW:   kernel_low  <= cfg_data;
        cvs_pkg::REG_KERNEL_HIGH:  kernel_high <= cfg_data;
        cvs_pkg::REG_IMAGE_WIDTH:  width_last  <= width_last_of(cfg_data[cvs_pkg::IMG_WIDTH_W-1:0]);
        cvs_pkg::REG_IMAGE_HEIGHT: height_last <= height_last_of(cfg_data[HW-1:0]);
      endcase
    end
  end

  // tap 0 lands in the low byte of the low word
  assign taps = {kernel_high, kernel_low};

  cvs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .restart     (restart),
    .width_last  (width_last),
    .height_last (height_last),
    .push        (push),
    .push_entry  (push_entry),
    .push_ready  (push_ready)
  );

  cvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  cvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .taps      (taps),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
